>>> hdl/eems_pkg.sv
// eems_pkg: shared constants, codes and pipeline types of the environment map sampler
`timescale 1ns / 1ps

package eems_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 512;
  localparam int CORDIC_STEPS = 16;

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDRW     = $clog2(MEM_DEPTH);

  // isqrt of a 48-bit radicand, one result bit per stage
  localparam int ISQ_N = 24;

  // pipeline stage positions
  localparam int S_IN    = 0;
  localparam int S_SQ    = 1;
  localparam int S_ISQ0  = 2;
  localparam int S_POLI  = S_ISQ0 + ISQ_N;
  localparam int S_POL0  = S_POLI + 1;
  localparam int S_MAP   = S_POL0 + CORDIC_STEPS;
  localparam int S_SPLIT = S_MAP + 1;
  localparam int S_ADDR  = S_SPLIT + 1;
  localparam int S_READ  = S_ADDR + 1;
  localparam int S_MIX   = S_READ + 1;
  localparam int S_PP    = S_MIX + 1;
  localparam int S_OUT   = S_PP + 1;
  localparam int NSTAGE  = S_OUT + 1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH      = 3'd0,
    REG_MAP_HEIGHT     = 3'd1,
    REG_TEXEL_CHANNELS = 3'd2,
    REG_MAP_LOADED     = 3'd3,
    REG_ROTATION_TURN  = 3'd4
  } cfg_reg_e;

  // atan(2^-i) in 1/2^32 turn
  localparam logic [31:0] ATAN_TURN [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // channel 0 red, 1 green, 2 blue
  typedef logic [2:0][31:0] texel_t;

  typedef struct packed {
    logic [30:0] red;
    logic [30:0] green;
    logic [30:0] blue;
  } result_t;

  typedef struct packed {
    logic                     cmd;
    logic [18:0]              addr_w;
    texel_t                   wdata;
    logic signed [15:0]       x;
    logic signed [15:0]       y;
    logic signed [15:0]       z;
    logic                     blank;
    logic                     yaxis;
    logic [31:0]              sq;
    logic [47:0]              rem;
    logic [47:0]              res;
    logic signed [34:0]       az_a;
    logic signed [34:0]       az_b;
    logic [31:0]              az_ang;
    logic signed [27:0]       pl_a;
    logic signed [27:0]       pl_b;
    logic signed [33:0]       pl_ang;
    logic [15:0]              u16;
    logic [16:0]              v16;
    logic signed [28:0]       xq;
    logic signed [28:0]       yq;
    logic [15:0]              tx;
    logic [15:0]              ty;
    logic [10:0]              cx0;
    logic [10:0]              cx1;
    logic [9:0]               cy0;
    logic [9:0]               cy1;
    logic [ADDRW-1:0]         ra0;
    logic [ADDRW-1:0]         ra1;
    logic [ADDRW-1:0]         ra2;
    logic [ADDRW-1:0]         ra3;
    logic [2:0][47:0]         top;
    logic [2:0][47:0]         bot;
    logic [2:0][41:0]         p_hi;
    logic [2:0][41:0]         p_lo;
    result_t                  rgb;
  } pipe_t;

endpackage

>>> hdl/equirect_env_map_bilinear_sampler.sv
// equirect_env_map_bilinear_sampler: pipelined texel store and bilinear environment lookup
`timescale 1ns / 1ps

// Input channel (in_valid_i/in_ready_o) carries write transactions (cmd 0), which store
// one signed Q16.16 RGB texel, and sample transactions (cmd 1), which give a Q1.14
// direction. Each sample produces one result transaction on the output channel
// (out_valid_o/out_ready_i); writes produce none. Both kinds keep their order.
// Throughput is one transaction per cycle while the output queue is not full. The pipeline
// runs 24 isqrt stages and 16 polar CORDIC stages in sequence, with the azimuth CORDIC
// running beside the isqrt. Four texels per sample come from two copies of the texel
// memory, each read at two addresses per cycle; writes update both copies at the read
// stage, so a sample sees exactly the writes accepted before it. A two-entry output
// queue holds finished results; the pipeline keeps moving while one result waits and
// holds as a whole when the queue is full.
// Reset empties the pipeline and queue and loads the default configuration; texel
// memory contents are undefined until written. Configuration is written through
// cfg_we_i/cfg_index_i/cfg_data_i while no transaction is in flight.
module equirect_env_map_bilinear_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [18:0] texel_address_i,
  input  logic signed [31:0] texel_red_i,
  input  logic signed [31:0] texel_green_i,
  input  logic signed [31:0] texel_blue_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [30:0] out_red_o,
  output logic [30:0] out_green_o,
  output logic [30:0] out_blue_o
);

  localparam int NST = eems_pkg::NSTAGE;
  localparam int AW  = eems_pkg::ADDRW;

  logic [10:0] map_width_q;
  logic [9:0]  map_height_q;
  logic [2:0]  texel_channels_q;
  logic        map_loaded_q;
  logic [15:0] rotation_turn_q;

  eems_pkg::pipe_t st_q [NST];
  eems_pkg::pipe_t nx   [NST];
  logic [NST-1:0]  vld_q;

  logic [3:0][95:0] rd_q;
  logic [95:0] mem_a_q [eems_pkg::MEM_DEPTH];
  logic [95:0] mem_b_q [eems_pkg::MEM_DEPTH];

  eems_pkg::result_t fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  logic en, push, pop, mem_wr;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;
  assign push       = en && vld_q[NST-1] && (st_q[NST-1].cmd == eems_pkg::CMD_SAMPLE);
  assign pop        = out_valid_o && out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q      <= 11'd1024;
      map_height_q     <= 10'd512;
      texel_channels_q <= 3'd3;
      map_loaded_q     <= 1'b0;
      rotation_turn_q  <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        eems_pkg::REG_MAP_WIDTH:      map_width_q      <= cfg_data_i[10:0];
        eems_pkg::REG_MAP_HEIGHT:     map_height_q     <= cfg_data_i[9:0];
        eems_pkg::REG_TEXEL_CHANNELS: texel_channels_q <= cfg_data_i[2:0];
        eems_pkg::REG_MAP_LOADED:     map_loaded_q     <= cfg_data_i[0];
        eems_pkg::REG_ROTATION_TURN:  rotation_turn_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic eems_pkg::pipe_t stage_step(
    input int              g,
    input eems_pkg::pipe_t p,
    input logic [3:0][95:0] tex,
    input logic [10:0]     cfg_w,
    input logic [9:0]      cfg_h,
    input logic [2:0]      cfg_ch,
    input logic            cfg_ld,
    input logic [15:0]     cfg_rot
  );
    eems_pkg::pipe_t n;
    int j, k, t;
    logic [10:0] wc;
    logic [9:0]  hc, hm1;
    logic signed [31:0] xs, zs;
    logic signed [34:0] ax, bz, da, db;
    logic signed [27:0] pa, pb;
    logic signed [23:0] ys;
    logic [47:0] bit_v, trial, rem_v, res_v;
    logic [31:0] phi;
    logic signed [33:0] ang_c, ang_r;
    logic [12:0] x0, y0, x1, y1;
    logic [3:0][2:0][30:0] cl;
    logic [16:0] wx0, wx1, wy0, wy1;
    logic [65:0] s;
    n = p;
    j = 0;
    wc = ({21'd0, cfg_w} > eems_pkg::MAX_WIDTH) ? 11'(eems_pkg::MAX_WIDTH) : cfg_w;
    hc = ({22'd0, cfg_h} > eems_pkg::MAX_HEIGHT) ? 10'(eems_pkg::MAX_HEIGHT) : cfg_h;
    hm1 = hc - 10'd1;
    if (g == eems_pkg::S_SQ) begin
      xs = {{16{p.x[15]}}, p.x};
      zs = {{16{p.z[15]}}, p.z};
      n.sq = 32'(xs * xs + zs * zs);
      n.yaxis = (p.x == 16'sd0) && (p.z == 16'sd0);
      n.blank = !cfg_ld || (cfg_ch < 3'd3) || (wc == 11'd0) || (hc == 10'd0) ||
                (n.yaxis && (p.y == 16'sd0));
      ax = {{19{p.x[15]}}, p.x} <<< 16;
      bz = {{19{p.z[15]}}, p.z} <<< 16;
      if (ax < 0) begin
        n.az_a = -ax;
        n.az_b = -bz;
        n.az_ang = 32'h8000_0000;
      end else begin
        n.az_a = ax;
        n.az_b = bz;
        n.az_ang = 32'd0;
      end
    end else if (g >= eems_pkg::S_ISQ0 && g < eems_pkg::S_ISQ0 + eems_pkg::ISQ_N) begin
      j = g - eems_pkg::S_ISQ0;
      // one isqrt result bit per stage
      if (j == 0) begin
        rem_v = {p.sq, 16'd0};
        res_v = 48'd0;
      end else begin
        rem_v = p.rem;
        res_v = p.res;
      end
      bit_v = 48'd1 << (46 - 2 * j);
      trial = res_v + bit_v;
      if (rem_v >= trial) begin
        n.rem = rem_v - trial;
        n.res = (res_v >> 1) + bit_v;
      end else begin
        n.rem = rem_v;
        n.res = res_v >> 1;
      end
      // azimuth cordic runs alongside
      if (j < eems_pkg::CORDIC_STEPS) begin
        da = p.az_b >>> j;
        db = p.az_a >>> j;
        if (!p.az_b[34]) begin
          n.az_a = p.az_a + da;
          n.az_b = p.az_b - db;
          n.az_ang = p.az_ang + eems_pkg::ATAN_TURN[j];
        end else begin
          n.az_a = p.az_a - da;
          n.az_b = p.az_b + db;
          n.az_ang = p.az_ang - eems_pkg::ATAN_TURN[j];
        end
      end
    end else if (g == eems_pkg::S_POLI) begin
      ys = {p.y, 8'd0};
      if (ys < 0) begin
        n.pl_a = 28'(p.res[23:0]);
        n.pl_b = -{{4{ys[23]}}, ys};
        n.pl_ang = 34'sd1073741824;
      end else begin
        n.pl_a = {{4{ys[23]}}, ys};
        n.pl_b = 28'(p.res[23:0]);
        n.pl_ang = 34'sd0;
      end
    end else if (g >= eems_pkg::S_POL0 && g < eems_pkg::S_POL0 + eems_pkg::CORDIC_STEPS) begin
      j = g - eems_pkg::S_POL0;
      pa = p.pl_b >>> j;
      pb = p.pl_a >>> j;
      if (!p.pl_b[27]) begin
        n.pl_a = p.pl_a + pa;
        n.pl_b = p.pl_b - pb;
        n.pl_ang = p.pl_ang + 34'(eems_pkg::ATAN_TURN[j]);
      end else begin
        n.pl_a = p.pl_a - pa;
        n.pl_b = p.pl_b + pb;
        n.pl_ang = p.pl_ang - 34'(eems_pkg::ATAN_TURN[j]);
      end
    end else if (g == eems_pkg::S_MAP) begin
      phi = p.az_ang + 32'h8000_0000 + {cfg_rot, 16'd0} + 32'h0000_8000;
      n.u16 = p.yaxis ? 16'h8000 : phi[31:16];
      if (p.pl_ang[33]) ang_c = 34'sd0;
      else if (p.pl_ang > 34'sh0_8000_0000) ang_c = 34'sh0_8000_0000;
      else ang_c = p.pl_ang;
      ang_r = ang_c + 34'sd32768;
      n.v16 = {ang_r[31:16], 1'b0};
      n.xq = 29'({13'd0, n.u16} * {18'd0, wc}) - 29'd32768;
      n.yq = 29'({12'd0, n.v16} * {19'd0, hc}) - 29'd32768;
    end else if (g == eems_pkg::S_SPLIT) begin
      x0 = p.xq[28:16];
      y0 = p.yq[28:16];
      n.tx = p.xq[15:0];
      n.ty = p.yq[15:0];
      x1 = x0 + 13'd1;
      y1 = y0 + 13'd1;
      // columns wrap, x0 lies in -1 .. width-1
      n.cx0 = x0[12] ? wc - 11'd1 : x0[10:0];
      n.cx1 = (x1 >= {2'd0, wc}) ? 11'(x1 - {2'd0, wc}) : x1[10:0];
      // rows clamp
      if (y0[12]) n.cy0 = 10'd0;
      else if (y0 > {3'd0, hm1}) n.cy0 = hm1;
      else n.cy0 = y0[9:0];
      if (y1[12]) n.cy1 = 10'd0;
      else if (y1 > {3'd0, hm1}) n.cy1 = hm1;
      else n.cy1 = y1[9:0];
    end else if (g == eems_pkg::S_ADDR) begin
      n.ra0 = AW'(21'({11'd0, p.cy0} * {10'd0, wc}) + {10'd0, p.cx0});
      n.ra1 = AW'(21'({11'd0, p.cy0} * {10'd0, wc}) + {10'd0, p.cx1});
      n.ra2 = AW'(21'({11'd0, p.cy1} * {10'd0, wc}) + {10'd0, p.cx0});
      n.ra3 = AW'(21'({11'd0, p.cy1} * {10'd0, wc}) + {10'd0, p.cx1});
    end else if (g == eems_pkg::S_MIX) begin
      wx1 = {1'b0, p.tx};
      wx0 = 17'h10000 - wx1;
      for (t = 0; t < 4; t++) begin
        for (k = 0; k < 3; k++) begin
          // negative channels read as zero
          cl[t][k] = tex[t][32*k+31] ? 31'd0 : tex[t][32*k +: 31];
        end
      end
      for (k = 0; k < 3; k++) begin
        n.top[k] = ({17'd0, cl[0][k]} * {31'd0, wx0}) + ({17'd0, cl[1][k]} * {31'd0, wx1});
        n.bot[k] = ({17'd0, cl[2][k]} * {31'd0, wx0}) + ({17'd0, cl[3][k]} * {31'd0, wx1});
      end
    end else if (g == eems_pkg::S_PP) begin
      wy1 = {1'b0, p.ty};
      wy0 = 17'h10000 - wy1;
      for (k = 0; k < 3; k++) begin
        n.p_hi[k] = ({18'd0, p.top[k][47:24]} * {25'd0, wy0}) +
                    ({18'd0, p.bot[k][47:24]} * {25'd0, wy1});
        n.p_lo[k] = ({18'd0, p.top[k][23:0]} * {25'd0, wy0}) +
                    ({18'd0, p.bot[k][23:0]} * {25'd0, wy1});
      end
    end else if (g == eems_pkg::S_OUT) begin
      for (k = 0; k < 3; k++) begin
        s = {p.p_hi[k], 24'd0} + {24'd0, p.p_lo[k]} + 66'h8000_0000;
        case (k)
          0: n.rgb.red = p.blank ? 31'd0 : s[62:32];
          1: n.rgb.green = p.blank ? 31'd0 : s[62:32];
          default: n.rgb.blue = p.blank ? 31'd0 : s[62:32];
        endcase
      end
    end
    return n;
  endfunction

  always_comb begin
    nx[0] = '0;
    nx[0].cmd = cmd_i;
    nx[0].addr_w = texel_address_i;
    nx[0].wdata[0] = texel_red_i;
    nx[0].wdata[1] = texel_green_i;
    nx[0].wdata[2] = texel_blue_i;
    nx[0].x = dir_x_i;
    nx[0].y = dir_y_i;
    nx[0].z = dir_z_i;
  end

  for (genvar g = 1; g < NST; g++) begin : g_stage
    assign nx[g] = stage_step(g, st_q[g-1], rd_q, map_width_q, map_height_q,
                              texel_channels_q, map_loaded_q, rotation_turn_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        st_q[i] <= nx[i];
      end
    end
  end

  // texel memories: two copies, each read at two addresses, written together
  assign mem_wr = vld_q[eems_pkg::S_ADDR] &&
                  (st_q[eems_pkg::S_ADDR].cmd == eems_pkg::CMD_WRITE) &&
                  ({13'd0, st_q[eems_pkg::S_ADDR].addr_w} < 32'(eems_pkg::MEM_DEPTH));

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q[0] <= mem_a_q[st_q[eems_pkg::S_ADDR].ra0];
      rd_q[1] <= mem_a_q[st_q[eems_pkg::S_ADDR].ra1];
      rd_q[2] <= mem_b_q[st_q[eems_pkg::S_ADDR].ra2];
      rd_q[3] <= mem_b_q[st_q[eems_pkg::S_ADDR].ra3];
      if (mem_wr) begin
        mem_a_q[AW'(st_q[eems_pkg::S_ADDR].addr_w)] <= st_q[eems_pkg::S_ADDR].wdata;
        mem_b_q[AW'(st_q[eems_pkg::S_ADDR].addr_w)] <= st_q[eems_pkg::S_ADDR].wdata;
      end
    end
  end

  // output queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= st_q[NST-1].rgb;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_red_o   = fifo_q[rd_ptr_q].red;
  assign out_green_o = fifo_q[rd_ptr_q].green;
  assign out_blue_o  = fifo_q[rd_ptr_q].blue;

endmodule

>>> sim/equirect_env_map_bilinear_sampler_tb.sv
// testbench for the equirectangular environment map bilinear sampler
`timescale 1ns / 1ps

module equirect_env_map_bilinear_sampler_tb;

  localparam int SETTLE_CYCLES = 60;
  localparam int IDLE_LIMIT    = 4000;

  class radiance_scoreboard;
    int unsigned width_reg = 1024;
    int unsigned height_reg = 512;
    int unsigned channels_reg = 3;
    int unsigned loaded_reg = 0;
    int unsigned rotation_reg = 0;
    eems_pkg::texel_t texels [int];
    eems_pkg::result_t pending_radiance [$];
    int errors = 0;

    function void set_reg(eems_pkg::cfg_reg_e idx, logic [15:0] val);
      case (idx)
        eems_pkg::REG_MAP_WIDTH:      width_reg = 32'(val[10:0]);
        eems_pkg::REG_MAP_HEIGHT:     height_reg = 32'(val[9:0]);
        eems_pkg::REG_TEXEL_CHANNELS: channels_reg = 32'(val[2:0]);
        eems_pkg::REG_MAP_LOADED:     loaded_reg = 32'(val[0]);
        eems_pkg::REG_ROTATION_TURN:  rotation_reg = 32'(val);
        default: ;
      endcase
    endfunction

    function longint vector_angle(longint a0, longint b0, longint ang0);
      longint a, b, ang, da, db;
      a = a0;
      b = b0;
      ang = ang0;
      for (int i = 0; i < eems_pkg::CORDIC_STEPS; i++) begin
        da = b >>> i;
        db = a >>> i;
        if (b >= 0) begin
          a += da; b -= db; ang += longint'(eems_pkg::ATAN_TURN[i]);
        end else begin
          a -= da; b += db; ang -= longint'(eems_pkg::ATAN_TURN[i]);
        end
      end
      return ang;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n0);
      longint unsigned n, res, bitv;
      n = n0;
      res = 0;
      bitv = 64'h1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void fetch(longint col, longint row, longint w, longint h,
                        output longint unsigned c [3]);
      longint cx, cy, addr;
      eems_pkg::texel_t t;
      cx = ((col % w) + w) % w;
      cy = row < 0 ? 0 : (row > h - 1 ? h - 1 : row);
      addr = (cy * w + cx) % eems_pkg::MEM_DEPTH;
      t = texels.exists(int'(addr)) ? texels[int'(addr)] : '0;
      for (int k = 0; k < 3; k++) c[k] = t[k][31] ? 64'd0 : 64'(t[k]);
    endfunction

    function eems_pkg::result_t lookup(logic signed [15:0] dx, logic signed [15:0] dy,
                                       logic signed [15:0] dz);
      eems_pkg::result_t r;
      longint x, y, z, w, h, a, b, t, ang, bx, by, x0, y0, tx, ty;
      longint unsigned rho, top, bot, s;
      longint unsigned c00 [3], c10 [3], c01 [3], c11 [3], mix [3];
      logic [31:0] phi;
      longint u16, v16;
      r = '0;
      x = longint'(dx); y = longint'(dy); z = longint'(dz);
      w = width_reg > eems_pkg::MAX_WIDTH ? eems_pkg::MAX_WIDTH : width_reg;
      h = height_reg > eems_pkg::MAX_HEIGHT ? eems_pkg::MAX_HEIGHT : height_reg;
      if (loaded_reg == 0 || channels_reg < 3 || w == 0 || h == 0) return r;
      if (x == 0 && y == 0 && z == 0) return r;
      if (x == 0 && z == 0) begin
        u16 = 32768;
      end else begin
        a = x * 65536; b = z * 65536; t = 0;
        if (a < 0) begin
          a = -a; b = -b; t = 64'sh80000000;
        end
        ang = vector_angle(a, b, t);
        phi = ang[31:0];
        phi = phi + 32'h80000000 + {rotation_reg[15:0], 16'h0000} + 32'h00008000;
        u16 = longint'(phi[31:16]);
      end
      rho = int_sqrt(64'(x * x + z * z) << 16);
      a = y * 256; b = longint'(rho); t = 0;
      if (a < 0) begin
        ang = a; a = b; b = -ang; t = 64'sh40000000;
      end
      ang = vector_angle(a, b, t);
      if (ang < 0) ang = 0;
      if (ang > 64'sh80000000) ang = 64'sh80000000;
      v16 = ((ang + 32768) >> 16) * 2;
      bx = u16 * w - 32768;
      by = v16 * h - 32768;
      x0 = bx >>> 16; y0 = by >>> 16;
      tx = bx & 65535; ty = by & 65535;
      fetch(x0, y0, w, h, c00);
      fetch(x0 + 1, y0, w, h, c10);
      fetch(x0, y0 + 1, w, h, c01);
      fetch(x0 + 1, y0 + 1, w, h, c11);
      for (int k = 0; k < 3; k++) begin
        top = c00[k] * longint'(65536 - tx) + c10[k] * longint'(tx);
        bot = c01[k] * longint'(65536 - tx) + c11[k] * longint'(tx);
        s = top * longint'(65536 - ty) + bot * longint'(ty);
        mix[k] = ((s + 64'h80000000) >> 32) & 64'h7FFFFFFF;
      end
      r.red = mix[0][30:0];
      r.green = mix[1][30:0];
      r.blue = mix[2][30:0];
      return r;
    endfunction

    function void note_input(logic cmd, logic [18:0] addr, eems_pkg::texel_t rgb,
                             logic signed [15:0] dx, logic signed [15:0] dy,
                             logic signed [15:0] dz);
      if (cmd == eems_pkg::CMD_WRITE) begin
        if (addr < eems_pkg::MEM_DEPTH) texels[int'(addr)] = rgb;
      end else begin
        pending_radiance.push_back(lookup(dx, dy, dz));
      end
    endfunction

    function void check(eems_pkg::result_t got);
      eems_pkg::result_t exp;
      if (pending_radiance.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      exp = pending_radiance.pop_front();
      if (got.red !== exp.red) begin
        $error("out_red expected %0h actual %0h", exp.red, got.red); errors++;
      end
      if (got.green !== exp.green) begin
        $error("out_green expected %0h actual %0h", exp.green, got.green); errors++;
      end
      if (got.blue !== exp.blue) begin
        $error("out_blue expected %0h actual %0h", exp.blue, got.blue); errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_i;
  logic [18:0] texel_address_i;
  logic signed [31:0] texel_red_i, texel_green_i, texel_blue_i;
  logic signed [15:0] dir_x_i, dir_y_i, dir_z_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [30:0] out_red_o, out_green_o, out_blue_o;

  radiance_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int region_size = 0;

  equirect_env_map_bilinear_sampler i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .texel_address_i,
    .texel_red_i, .texel_green_i, .texel_blue_i,
    .dir_x_i, .dir_y_i, .dir_z_i,
    .out_valid_o, .out_ready_i, .out_red_o, .out_green_o, .out_blue_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // monitors both channels and the progress watchdog
  always @(posedge clk_i) begin
    eems_pkg::texel_t rgb;
    eems_pkg::result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        rgb = {texel_blue_i, texel_green_i, texel_red_i};
        sb.note_input(cmd_i, texel_address_i, rgb, dir_x_i, dir_y_i, dir_z_i);
      end
      if (out_valid_o && out_ready_i) begin
        got.red = out_red_o;
        got.green = out_green_o;
        got.blue = out_blue_o;
        sb.check(got);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("equirect_env_map_bilinear_sampler_tb NOT OK");
          $finish;
        end
      end
    end
  end

  // receiver stall pattern: randomly chosen modes of free flow, random and long stalls
  always @(negedge clk_i) begin
    int stall_left;
    int mode_left;
    int mode;
    if (mode_left == 0) begin
      mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i = 1'b0;
    end else if (mode == 0) begin
      out_ready_i = 1'b1;
    end else if (mode == 1) begin
      out_ready_i = ($urandom_range(0, 99) < 65);
    end else begin
      out_ready_i = 1'b1;
      if ($urandom_range(0, 99) < 5) stall_left = $urandom_range(5, 30);
    end
  end

  task automatic send(logic cmd, logic [18:0] addr, logic [31:0] r, logic [31:0] g,
                      logic [31:0] b, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    cmd_i = cmd;
    texel_address_i = addr;
    texel_red_i = r;
    texel_green_i = g;
    texel_blue_i = b;
    dir_x_i = x;
    dir_y_i = y;
    dir_z_i = z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic write_texel(logic [18:0] addr);
    send(eems_pkg::CMD_WRITE, addr, $urandom, $urandom, $urandom,
         16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    send(eems_pkg::CMD_SAMPLE, 19'($urandom), $urandom, $urandom, $urandom, x, y, z);
  endtask

  // reconfigures only once the pipeline has drained
  task automatic configure(int w, int h, int ch, int loaded, int rot);
    int ew, eh;
    eems_pkg::cfg_reg_e idx;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_radiance.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 5; i++) begin
      @(negedge clk_i);
      idx = eems_pkg::cfg_reg_e'(i);
      cfg_we_i = 1'b1;
      cfg_index_i = idx;
      case (idx)
        eems_pkg::REG_MAP_WIDTH:      cfg_data_i = 16'(w);
        eems_pkg::REG_MAP_HEIGHT:     cfg_data_i = 16'(h);
        eems_pkg::REG_TEXEL_CHANNELS: cfg_data_i = 16'(ch);
        eems_pkg::REG_MAP_LOADED:     cfg_data_i = 16'(loaded);
        default:                      cfg_data_i = 16'(rot);
      endcase
      sb.set_reg(idx, cfg_data_i);
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    ew = (w & 16'h7FF) > eems_pkg::MAX_WIDTH ? eems_pkg::MAX_WIDTH : (w & 16'h7FF);
    eh = (h & 16'h3FF) > eems_pkg::MAX_HEIGHT ? eems_pkg::MAX_HEIGHT : (h & 16'h3FF);
    region_size = ew * eh;
    // every texel that a sample can touch is written before any sample
    if (loaded != 0 && ch >= 3)
      for (int a = 0; a < region_size; a++) write_texel(19'(a));
  endtask

  function automatic logic [15:0] rand_component();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 16'($urandom);
    if (sel < 8) return 16'($urandom_range(0, 6) - 3);
    if (sel == 8) return 16'h0000;
    return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
  endfunction

  task automatic random_traffic(int count);
    logic [15:0] x, z;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 20) begin
        if (region_size > 0 && $urandom_range(0, 3) != 0)
          write_texel(19'($urandom_range(0, region_size - 1)));
        else
          write_texel(19'($urandom));
      end else begin
        x = rand_component();
        z = rand_component();
        if ($urandom_range(0, 19) == 0) begin
          x = '0; z = '0;
        end
        sample(x, rand_component(), z);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = eems_pkg::REG_MAP_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cmd_i = eems_pkg::CMD_WRITE;
    texel_address_i = '0;
    texel_red_i = '0;
    texel_green_i = '0;
    texel_blue_i = '0;
    dir_x_i = '0;
    dir_y_i = '0;
    dir_z_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults: map not loaded, so samples are black
    sample(16'h4000, 16'h1000, 16'h2000);
    sample(16'h0000, 16'h0000, 16'h0000);

    configure(4, 2, 3, 1, 0);
    // negative and extreme texel channels
    send(eems_pkg::CMD_WRITE, 19'd0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
         16'd0, 16'd0, 16'd0);
    send(eems_pkg::CMD_WRITE, 19'd5, 32'h7FFFFFFF, 32'h00000000, 32'h80000001,
         16'd0, 16'd0, 16'd0);
    sample(16'h0000, 16'h0000, 16'h0000);
    sample(16'h4000, 16'h0000, 16'h0000);
    sample(16'hC000, 16'h0000, 16'h0000);
    sample(16'h0000, 16'h0000, 16'h4000);
    sample(16'h0000, 16'h0000, 16'hC000);
    sample(16'h0000, 16'h4000, 16'h0000);
    sample(16'h0000, 16'hC000, 16'h0000);
    sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    sample(16'h8000, 16'h8000, 16'h8000);
    sample(16'h8000, 16'h0000, 16'hFFFF);
    sample(16'h0001, 16'h8000, 16'h0000);
    sample(16'hFFFF, 16'h7FFF, 16'h0001);
    random_traffic(50);

    configure(1, 1, 3, 1, 65535);
    sample(16'h0000, 16'h4000, 16'h0000);
    random_traffic(40);
    // oversized width is used at the parameter size
    configure(2000, 1, 3, 1, $urandom_range(0, 65535));
    random_traffic(40);
    configure(16, 8, 4, 1, $urandom_range(0, 65535));
    random_traffic(40);
    configure(3, 5, 3, 1, $urandom_range(0, 65535));
    random_traffic(40);
    // black cases (too few channels, zero size, map not loaded) and one 2x1 map at half-turn rotation
    configure(7, 3, 2, 1, 1234);
    random_traffic(20);
    configure(0, 4, 3, 1, 0);
    random_traffic(10);
    configure(8, 0, 3, 1, 0);
    random_traffic(10);
    configure(5, 5, 3, 0, $urandom_range(0, 65535));
    random_traffic(10);
    configure(2, 1, 3, 1, 32768);
    random_traffic(20);
    configure(5, 3, 1, 1, 0);
    random_traffic(10);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_radiance.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_radiance.size() == 0)
      $display("equirect_env_map_bilinear_sampler_tb OK");
    else
      $display("equirect_env_map_bilinear_sampler_tb NOT OK");
    $finish;
  end

endmodule

>>> equirect_env_map_bilinear_sampler.f
hdl/eems_pkg.sv
hdl/equirect_env_map_bilinear_sampler.sv
sim/equirect_env_map_bilinear_sampler_tb.sv
